/* hw/rtl/drp_pkg.sv */
`timescale 1ns / 1ps
package drp_pkg;

  localparam int unsigned MaxDims  = 4;
  localparam int unsigned MaxRadix = 16;
  localparam int unsigned NodeW    = 16;
  localparam int unsigned DigW     = $clog2(MaxRadix);
  localparam int unsigned RadixW   = 5;
  localparam int unsigned DimsW    = 3;
  localparam int unsigned OffW     = 5;
  localparam int unsigned CntW     = 6;
  localparam int unsigned DimIdxW  = $clog2(MaxDims);
  localparam int unsigned PowW     = NodeW + 1;
  localparam int unsigned CfgIdxW  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWrap  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRadix = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDims  = 2'd2;

  typedef logic signed [OffW-1:0] offset_t;

  typedef struct packed {
    logic                            err;
    logic [NodeW-1:0]                src_node;
    logic [MaxDims-1:0][DigW-1:0]    digits;
    offset_t [MaxDims-1:0]           offs;
    logic [CntW-1:0]                 path_len;
    logic [RadixW-1:0]               radix;
    logic [MaxDims-1:0][NodeW-1:0]   weight;
    logic [MaxDims-1:0][NodeW-1:0]   wrap_delta;
  } route_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* hw/rtl/drp_front.sv */
`timescale 1ns / 1ps
module drp_front import drp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NodeW-1:0]    src_i,
  input  logic [NodeW-1:0]    dst_i,
  input  logic                wrap_i,
  input  logic [RadixW-1:0]   radix_i,
  input  logic [DimsW-1:0]    dims_i,
  input  queue_status_t       qstat_i,
  output logic                push_o,
  output route_job_t          job_o
);

  localparam int unsigned PcntW  = $clog2(MaxDims + 1);
  localparam int unsigned BitW   = $clog2(DigW);
  localparam int unsigned TrialW = PowW + DigW - 1;
  localparam int unsigned ProdW  = PowW + RadixW;
  localparam int unsigned DiffW  = RadixW + 1;

  typedef enum logic [1:0] {FeIdle, FePow, FeDigit, FePush} fe_state_e;

  fe_state_e                     state_q;
  logic [PcntW-1:0]              pcnt_q;
  logic [DimIdxW-1:0]            dim_q;
  logic [BitW-1:0]               bit_q;
  logic [NodeW-1:0]              src_node_q, src_rem_q, dst_rem_q;
  logic [RadixW-1:0]             k_q;
  logic [DimsW-1:0]              nd_q;
  logic                          wrap_q;
  logic                          err_q;
  logic [PowW-1:0]               pw_q [MaxDims+1];
  logic [NodeW-1:0]              wd_q [MaxDims];
  logic [MaxDims-1:0][DigW-1:0]  sdig_q, ddig_q;

  logic                          accept;
  logic [RadixW-1:0]             k_eff;
  logic [DimsW-1:0]              nd_eff;
  logic [PcntW-1:0]              rd_idx;
  logic [PowW-1:0]               pw_rd;
  logic [ProdW-1:0]              prod;
  logic [PowW-1:0]               prod_w;
  logic                          pow_done, range_bad;
  logic [TrialW-1:0]             trial;
  logic                          ge_s, ge_d;

  assign accept     = (state_q == FeIdle) && in_valid_i;
  assign in_ready_o = (state_q == FeIdle);
  assign push_o     = (state_q == FePush) && !qstat_i.full;

  always_comb begin
    if (radix_i < RadixW'(2))             k_eff = RadixW'(2);
    else if (radix_i > RadixW'(MaxRadix)) k_eff = RadixW'(MaxRadix);
    else                                  k_eff = radix_i;
    if (dims_i == '0)                     nd_eff = DimsW'(1);
    else if (dims_i > DimsW'(MaxDims))    nd_eff = DimsW'(MaxDims);
    else                                  nd_eff = dims_i;
  end

  // the power and digit steps share one read port on the power table
  assign rd_idx    = (state_q == FePow) ? pcnt_q : PcntW'(dim_q);
  assign pw_rd     = pw_q[rd_idx];
  assign prod      = ProdW'(pw_rd) * ProdW'(k_q);
  assign prod_w    = PowW'(prod);
  assign pow_done  = (DimsW'(pcnt_q) + DimsW'(1)) == nd_q;
  assign range_bad = (PowW'(src_rem_q) >= prod_w) || (PowW'(dst_rem_q) >= prod_w);

  // restoring step: quotient digit fits DigW bits since remainder < radix * weight
  assign trial = TrialW'(pw_rd) << bit_q;
  assign ge_s  = TrialW'(src_rem_q) >= trial;
  assign ge_d  = TrialW'(dst_rem_q) >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
    end else begin
      case (state_q)
        FeIdle:  if (accept) state_q <= FePow;
        FePow: begin
          if (pow_done) state_q <= range_bad ? FePush : FeDigit;
        end
        FeDigit: if (bit_q == '0 && dim_q == '0) state_q <= FePush;
        FePush:  if (!qstat_i.full) state_q <= FeIdle;
        default: state_q <= FeIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FeIdle: begin
        if (accept) begin
          src_node_q <= src_i;
          src_rem_q  <= src_i;
          dst_rem_q  <= dst_i;
          k_q        <= k_eff;
          nd_q       <= nd_eff;
          wrap_q     <= wrap_i;
          pw_q[0]    <= PowW'(1);
          pcnt_q     <= '0;
          sdig_q     <= '0;
          ddig_q     <= '0;
          err_q      <= 1'b0;
        end
      end
      FePow: begin
        pw_q[PcntW'(pcnt_q + PcntW'(1))] <= prod_w;
        wd_q[DimIdxW'(pcnt_q)]           <= NodeW'(prod_w - pw_rd);
        pcnt_q                           <= PcntW'(pcnt_q + PcntW'(1));
        if (pow_done) begin
          err_q <= range_bad;
          dim_q <= DimIdxW'(nd_q - DimsW'(1));
          bit_q <= BitW'(DigW - 1);
        end
      end
      FeDigit: begin
        sdig_q[dim_q][bit_q] <= ge_s;
        ddig_q[dim_q][bit_q] <= ge_d;
        if (ge_s) src_rem_q <= NodeW'(TrialW'(src_rem_q) - trial);
        if (ge_d) dst_rem_q <= NodeW'(TrialW'(dst_rem_q) - trial);
        if (bit_q == '0) begin
          bit_q <= BitW'(DigW - 1);
          if (dim_q != '0) dim_q <= dim_q - DimIdxW'(1);
        end else begin
          bit_q <= bit_q - BitW'(1);
        end
      end
      default: ;
    endcase
  end

  logic signed [DiffW-1:0] diff [MaxDims];
  logic signed [DiffW-1:0] half_s, k_s;
  logic                    cube;

  always_comb begin
    half_s = $signed({1'b0, k_q >> 1});
    k_s    = $signed({1'b0, k_q});
    cube   = !wrap_q && (k_q == RadixW'(2)) && (nd_q >= DimsW'(2));
    job_o.err      = err_q;
    job_o.src_node = src_node_q;
    job_o.digits   = sdig_q;
    job_o.radix    = k_q;
    job_o.path_len = '0;
    for (int i = 0; i < MaxDims; i++) begin
      diff[i] = $signed(DiffW'(ddig_q[i])) - $signed(DiffW'(sdig_q[i]));
      if (cube) begin
        diff[i] = $signed(DiffW'(ddig_q[i] ^ sdig_q[i]));
      end else if (wrap_q) begin
        if (diff[i] > half_s)  diff[i] = diff[i] - k_s;
        if (diff[i] < -half_s) diff[i] = diff[i] + k_s;
      end
      job_o.offs[i]       = OffW'(diff[i]);
      job_o.path_len      = job_o.path_len +
                            CntW'(diff[i] < 0 ? -diff[i] : diff[i]);
      job_o.weight[i]     = NodeW'(pw_q[i]);
      job_o.wrap_delta[i] = wd_q[i];
    end
  end

endmodule

/* hw/rtl/drp_queue.sv */
`timescale 1ns / 1ps
module drp_queue import drp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  route_job_t    job_i,
  input  logic          pop_i,
  output route_job_t    job_o,
  output queue_status_t status_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW2 = $clog2(Depth + 1);

  route_job_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW2-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CntW2'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign job_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW2'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW2'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW2'(Depth)) else $error("queue count over depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full || pop_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/drp_back.sv */
`timescale 1ns / 1ps
module drp_back import drp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  route_job_t           job_i,
  input  queue_status_t        qstat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NodeW-1:0]     hop_node_o,
  output logic [CntW-1:0]      hop_index_o,
  output logic [CntW-1:0]      distance_o,
  output offset_t [MaxDims-1:0] offs_o,
  output logic                 range_error_o,
  output logic                 last_o
);

  logic                          active_q, ov_q;
  logic [MaxDims-1:0][DigW-1:0]  dig_q;
  offset_t                       rem_q [MaxDims];
  offset_t [MaxDims-1:0]         offs_q;
  logic [NodeW-1:0]              node_q;
  logic [CntW-1:0]               hop_q, dist_q;
  logic [RadixW-1:0]             k_q;
  logic [MaxDims-1:0][NodeW-1:0] w_q, wd_q;

  logic [NodeW-1:0]              o_node_q;
  logic [CntW-1:0]               o_hop_q, o_dist_q;
  offset_t [MaxDims-1:0]         o_offs_q;
  logic                          o_err_q, o_last_q;

  logic                          advance, step;
  logic [DimIdxW-1:0]            sel;
  logic [MaxDims-1:0]            rem_nz;
  logic [DigW-1:0]               cur, kmax, nxt_dig;
  offset_t                       nxt_rem;
  logic [NodeW-1:0]              nxt_node;

  assign advance = !ov_q || out_ready_i;
  assign pop_o   = advance && !active_q && !qstat_i.empty;
  assign step    = advance && active_q;

  // lowest dimension with hops left goes first
  always_comb begin
    sel = '0;
    for (int i = MaxDims - 1; i >= 0; i--) begin
      rem_nz[i] = (rem_q[i] != '0);
      if (rem_nz[i]) sel = DimIdxW'(i);
    end
  end

  always_comb begin
    cur  = dig_q[sel];
    kmax = DigW'(k_q - RadixW'(1));
    if (rem_q[sel][OffW-1]) begin
      nxt_rem = rem_q[sel] + OffW'(1);
      if (cur == '0) begin
        nxt_dig  = kmax;
        nxt_node = node_q + wd_q[sel];
      end else begin
        nxt_dig  = cur - DigW'(1);
        nxt_node = node_q - w_q[sel];
      end
    end else begin
      nxt_rem = rem_q[sel] - OffW'(1);
      if (cur == kmax) begin
        nxt_dig  = '0;
        nxt_node = node_q - wd_q[sel];
      end else begin
        nxt_dig  = cur + DigW'(1);
        nxt_node = node_q + w_q[sel];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else if (pop_o) begin
      ov_q     <= 1'b1;
      active_q <= !job_i.err && (job_i.path_len != '0);
    end else if (step) begin
      ov_q     <= 1'b1;
      active_q <= (hop_q != dist_q);
    end else if (advance) begin
      ov_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      o_err_q  <= job_i.err;
      o_hop_q  <= '0;
      o_last_q <= job_i.err || (job_i.path_len == '0);
      if (job_i.err) begin
        o_node_q <= '0;
        o_dist_q <= '0;
        o_offs_q <= '0;
      end else begin
        o_node_q <= job_i.src_node;
        o_dist_q <= job_i.path_len;
        o_offs_q <= job_i.offs;
      end
      node_q <= job_i.src_node;
      hop_q  <= CntW'(1);
      dist_q <= job_i.path_len;
      dig_q  <= job_i.digits;
      offs_q <= job_i.offs;
      k_q    <= job_i.radix;
      w_q    <= job_i.weight;
      wd_q   <= job_i.wrap_delta;
      for (int i = 0; i < MaxDims; i++) rem_q[i] <= job_i.offs[i];
    end else if (step) begin
      dig_q[sel] <= nxt_dig;
      rem_q[sel] <= nxt_rem;
      node_q     <= nxt_node;
      hop_q      <= hop_q + CntW'(1);
      o_node_q   <= nxt_node;
      o_hop_q    <= hop_q;
      o_dist_q   <= dist_q;
      o_offs_q   <= offs_q;
      o_err_q    <= 1'b0;
      o_last_q   <= (hop_q == dist_q);
    end
  end

  assign out_valid_o   = ov_q;
  assign hop_node_o    = o_node_q;
  assign hop_index_o   = o_hop_q;
  assign distance_o    = o_dist_q;
  assign offs_o        = o_offs_q;
  assign range_error_o = o_err_q;
  assign last_o        = o_last_q;

`ifndef SYNTH
  a_active_has_hops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rem_nz != '0)) else $error("walk active with no hops left");
  a_hop_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !o_err_q |-> o_hop_q <= o_dist_q) else $error("hop index past distance");
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && o_err_q |-> o_last_q && !active_q) else $error("range error not final");
`endif

endmodule

/* hw/rtl/dimension_order_route_path.sv */
`timescale 1ns / 1ps
// front: accept, radix powers, digit extraction bit by bit (none on a range error), push
// back: one node per cycle if tready, distance + 1 nodes per request; one on a range error
// new input taken only once the front has pushed its last job into the two-entry job queue
// reset: asynchronous active low; clears control, config back to mesh, radix 4, 2 dimensions
module dimension_order_route_path import drp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [31:0]         s_axis_tdata_i,  // source_node, dest_node
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // hop_node, hop_index, distance, offset_dim0, offset_dim1, offset_dim2, offset_dim3
  output logic [47:0]         m_axis_tdata_o,
  output logic                m_axis_tuser_o,  // range_error
  output logic                m_axis_tlast_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RadixW-1:0]   cfg_data_i
);

  logic                  wrap_q;
  logic [RadixW-1:0]     radix_q;
  logic [DimsW-1:0]      dims_q;

  logic                  push, pop;
  route_job_t            job_in, job_out;
  queue_status_t         qstat;
  logic [NodeW-1:0]      hop_node;
  logic [CntW-1:0]       hop_index, distance;
  offset_t [MaxDims-1:0] offs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q  <= 1'b0;
      radix_q <= RadixW'(4);
      dims_q  <= DimsW'(2);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWrap:  wrap_q  <= cfg_data_i[0];
        CfgRadix: radix_q <= cfg_data_i;
        CfgDims:  dims_q  <= cfg_data_i[DimsW-1:0];
        default: ;
      endcase
    end
  end

  drp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .src_i      (s_axis_tdata_i[15:0]),
    .dst_i      (s_axis_tdata_i[31:16]),
    .wrap_i     (wrap_q),
    .radix_i    (radix_q),
    .dims_i     (dims_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_o      (job_in)
  );

  drp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .job_o    (job_out),
    .status_o (qstat)
  );

  drp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .hop_node_o    (hop_node),
    .hop_index_o   (hop_index),
    .distance_o    (distance),
    .offs_o        (offs),
    .range_error_o (m_axis_tuser_o),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {offs, distance, hop_index, hop_node};

endmodule
